// File: rtl/core/frma_pkg.sv
// Shared types and constants for the FIFO random machine allocator.
package frma_pkg;

  localparam int JOB_W      = 16;
  localparam int NEED_W     = 6;
  localparam int MIDX_W     = 5;
  localparam int STATUS_W   = 2;
  localparam int SEED_W     = 16;
  localparam int PRESENT_W  = 6;
  localparam int MAX_RESULTS = 32;
  localparam int RES_W      = 6;

  localparam logic [SEED_W-1:0] LFSR_TAPS = 16'hB400;

  localparam logic [STATUS_W-1:0] ST_GRANTED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJ_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJ_ZERO  = 2'd2;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_FREE = 1'b1;

  localparam int REG_SEED    = 0;
  localparam int REG_PRESENT = 1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_req;     // latch the accepted request and apply free
    logic enqueue;      // write the request into the job queue
    logic load_head;    // read the head entry and count free machines
    logic start_mod;    // step the LFSR and start the modulo
    logic mod_step;     // one restoring-division step
    logic scan_start;   // start the rank search
    logic scan_step;    // one bit of the rank search
    logic commit_pick;  // mark the found machine busy, load grant
    logic pop;          // retire the head job
    logic load_reject;  // load a rejection result
  } frma_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_is_free;
    logic req_eos;
    logic need_zero;
    logic queue_full;
    logic queue_empty;
    logic count_busy;   // free machine count still running
    logic head_fits;    // need <= free count and within result budget
    logic mod_done;
    logic scan_hit;
    logic picks_done;   // all picks for the head job made
  } frma_stat_t;

endpackage

// File: rtl/core/fifo_random_machine_allocator.sv
// Top level of the FIFO random machine allocator.
//
//  Channel   Signals                                              Direction
//  in        in_valid/in_stall, req_type, job_id, need_count,     sink
//            machine_index, end_of_set
//  out       out_valid/out_stall, grant_job, granted_machine,     source
//            status, last_of_run
//  cfg       psel, penable, pwrite, paddr, pwdata, prdata, pready slave
//
// One request is handled at a time: it is accepted, then decoded. For each
// head job the queue head is read and the free machines are counted one per
// cycle, and each pick takes an LFSR step, a modulo by restoring division, a
// rank search over the free map and a commit. A grant is held until the next
// pick or the end of the pass shows whether it is the last. Reset is
// synchronous; all machines present are free and the queue is empty. A
// stalled result holds the allocation, and the input stays stalled until the
// request is finished.
module fifo_random_machine_allocator #(
  parameter int NUM_MACHINES = 32,
  parameter int QUEUE_DEPTH  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [15:0] job_id,
  input  logic [5:0]  need_count,
  input  logic [4:0]  machine_index,
  input  logic        end_of_set,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] grant_job,
  output logic [4:0]  granted_machine,
  output logic [1:0]  status,
  output logic        last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  frma_pkg::frma_cmd_t  cmd;
  frma_pkg::frma_stat_t stat;
  logic [15:0] seed_q;
  logic [5:0]  present_q;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  // Registers sit on word addresses, so bit 2 of the address picks one.
  always_comb begin
    case (paddr[2])
      1'(frma_pkg::REG_SEED): prdata = {16'd0, seed_q};
      default: prdata = {26'd0, present_q};
    endcase
  end

  frma_datapath #(.NUM_MACHINES(NUM_MACHINES), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk, .rst, .cmd, .stat,
    .in_req_type(req_type), .in_job_id(job_id), .in_need_count(need_count),
    .in_machine_index(machine_index), .in_end_of_set(end_of_set),
    .cfg_seed_we(wr && paddr[2] == 1'(frma_pkg::REG_SEED)),
    .cfg_present_we(wr && paddr[2] == 1'(frma_pkg::REG_PRESENT)),
    .cfg_wdata(pwdata), .seed_q, .present_q,
    .res_job(grant_job), .res_machine(granted_machine), .res_status(status)
  );

  frma_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .out_last(last_of_run), .stat, .cmd
  );
endmodule

// File: rtl/core/frma_datapath.sv
// Datapath: free map, job queue memory, LFSR, modulo unit and rank search.
module frma_datapath #(
  parameter int NUM_MACHINES = 32,
  parameter int QUEUE_DEPTH  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  frma_pkg::frma_cmd_t             cmd,
  output frma_pkg::frma_stat_t            stat,
  input  logic                            in_req_type,
  input  logic [frma_pkg::JOB_W-1:0]      in_job_id,
  input  logic [frma_pkg::NEED_W-1:0]     in_need_count,
  input  logic [frma_pkg::MIDX_W-1:0]     in_machine_index,
  input  logic                            in_end_of_set,
  input  logic                            cfg_seed_we,
  input  logic                            cfg_present_we,
  input  logic [31:0]                     cfg_wdata,
  output logic [frma_pkg::SEED_W-1:0]     seed_q,
  output logic [frma_pkg::PRESENT_W-1:0]  present_q,
  output logic [frma_pkg::JOB_W-1:0]      res_job,
  output logic [frma_pkg::MIDX_W-1:0]     res_machine,
  output logic [frma_pkg::STATUS_W-1:0]   res_status
);
  localparam int MW = (NUM_MACHINES > 1) ? $clog2(NUM_MACHINES) : 1;
  localparam int CW = $clog2(NUM_MACHINES + 1);
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = frma_pkg::SEED_W;
  localparam int EW = frma_pkg::JOB_W + frma_pkg::NEED_W;

  logic [EW-1:0] qmem [QUEUE_DEPTH];
  logic [EW-1:0] head_rd;
  logic [QW-1:0] qhead, qtail;
  logic [QCW-1:0] qcount;

  logic [NUM_MACHINES-1:0] free_map;
  logic [SW-1:0] lfsr, lfsr_step;
  logic req_type;
  logic [frma_pkg::JOB_W-1:0] req_job;
  logic [frma_pkg::NEED_W-1:0] req_need;
  logic req_eos;
  logic [frma_pkg::NEED_W-1:0] picks_left;
  logic [CW-1:0] nfree;
  logic [frma_pkg::RES_W:0] nres;
  logic [SW-1:0] rem;
  logic [SW-1:0] dividend;
  logic [4:0] mod_cnt;
  logic [MW-1:0] scan_idx;
  logic [CW-1:0] rank;
  logic [CW-1:0] pop_cnt;
  logic [MW:0] pc_idx;
  logic counting;

  always_comb begin
    lfsr_step = lfsr >> 1;
    if (lfsr[0]) lfsr_step = lfsr_step ^ frma_pkg::LFSR_TAPS;
  end

  function automatic logic [NUM_MACHINES-1:0] pmask(input logic [frma_pkg::PRESENT_W-1:0] n);
    logic [NUM_MACHINES-1:0] m;
    m = '0;
    for (int i = 0; i < NUM_MACHINES; i++)
      if (i < int'(n)) m[i] = 1'b1;
    return m;
  endfunction

  logic [frma_pkg::PRESENT_W-1:0] wr_present;
  always_comb begin
    wr_present = cfg_wdata[frma_pkg::PRESENT_W-1:0];
    if (int'(wr_present) > NUM_MACHINES) wr_present = frma_pkg::PRESENT_W'(NUM_MACHINES);
  end

  // Queue memory: one write, one registered read.
  always_ff @(posedge clk) begin
    if (cmd.enqueue) qmem[qtail] <= {req_need, req_job};
    head_rd <= qmem[qhead];
  end

  logic [frma_pkg::NEED_W-1:0] head_need;
  assign head_need = head_rd[EW-1:frma_pkg::JOB_W];
  logic [SW-1:0] rem_sh;
  logic [SW:0] rem_try;
  assign rem_sh  = {rem[SW-2:0], dividend[SW-1]};
  assign rem_try = {1'b0, rem_sh} - {{(SW+1-CW){1'b0}}, nfree};

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_q <= 16'd1;
      present_q <= frma_pkg::PRESENT_W'((NUM_MACHINES < 32) ? NUM_MACHINES : 32);
      free_map <= pmask(frma_pkg::PRESENT_W'((NUM_MACHINES < 32) ? NUM_MACHINES : 32));
      lfsr <= 16'd1;
      qhead <= '0; qtail <= '0; qcount <= '0;
      counting <= 1'b0;
      nres <= '0;
    end else begin
      if (cfg_seed_we) begin
        seed_q <= cfg_wdata[SW-1:0];
        lfsr <= (cfg_wdata[SW-1:0] == '0) ? SW'(1) : cfg_wdata[SW-1:0];
      end
      if (cfg_present_we) begin
        present_q <= wr_present;
        free_map <= pmask(wr_present);
      end
      if (cmd.take_req) begin
        req_type <= in_req_type; req_job <= in_job_id; req_need <= in_need_count;
        req_eos <= in_end_of_set;
        nres <= '0;
        if (in_req_type == frma_pkg::REQ_FREE && int'(in_machine_index) < int'(present_q)
            && int'(in_machine_index) < NUM_MACHINES)
          free_map[in_machine_index[MW-1:0]] <= 1'b1;
      end
      if (cmd.enqueue) begin
        qtail <= (int'(qtail) == QUEUE_DEPTH-1) ? '0 : qtail + 1'b1;
        qcount <= qcount + 1'b1;
      end
      // load_head: start popcount over free map, one bit per cycle
      if (cmd.load_head) begin
        counting <= 1'b1; pc_idx <= '0; pop_cnt <= '0;
        picks_left <= '0;
      end else if (counting) begin
        if (free_map[pc_idx[MW-1:0]]) pop_cnt <= pop_cnt + 1'b1;
        if (int'(pc_idx) == NUM_MACHINES-1) counting <= 1'b0;
        pc_idx <= pc_idx + 1'b1;
      end
      if (cmd.start_mod) begin
        if (picks_left == '0) begin
          picks_left <= head_need;
          nfree <= pop_cnt;
        end
        lfsr <= lfsr_step; dividend <= lfsr_step; rem <= '0; mod_cnt <= '0;
      end
      if (cmd.mod_step) begin
        if (!rem_try[SW]) rem <= rem_try[SW-1:0]; else rem <= rem_sh;
        dividend <= dividend << 1;
        mod_cnt <= mod_cnt + 1'b1;
      end
      if (cmd.scan_start) begin
        scan_idx <= '0; rank <= rem[CW-1:0];
      end
      if (cmd.scan_step && !stat.scan_hit) begin
        if (free_map[scan_idx]) rank <= rank - 1'b1;
        scan_idx <= scan_idx + 1'b1;
      end
      if (cmd.commit_pick) begin
        free_map[scan_idx] <= 1'b0;
        nfree <= nfree - 1'b1;
        picks_left <= picks_left - 1'b1;
        nres <= nres + 1'b1;
        res_job <= head_rd[frma_pkg::JOB_W-1:0];
        res_machine <= frma_pkg::MIDX_W'(scan_idx);
        res_status <= frma_pkg::ST_GRANTED;
      end
      if (cmd.pop) begin
        qhead <= (int'(qhead) == QUEUE_DEPTH-1) ? '0 : qhead + 1'b1;
        qcount <= qcount - 1'b1;
      end
      if (cmd.load_reject) begin
        res_job <= req_job; res_machine <= '0;
        res_status <= (req_need == '0) ? frma_pkg::ST_REJ_ZERO : frma_pkg::ST_REJ_FULL;
      end
    end
  end

  always_comb begin
    stat.req_is_free = req_type;
    stat.req_eos     = req_eos;
    stat.need_zero   = (req_need == '0);
    stat.queue_full  = (int'(qcount) >= QUEUE_DEPTH);
    stat.queue_empty = (qcount == '0);
    stat.count_busy  = counting;
    stat.head_fits   = !counting && (int'(head_need) <= int'(pop_cnt)) &&
                       (int'(nres) + int'(head_need) <= frma_pkg::MAX_RESULTS);
    stat.mod_done    = (int'(mod_cnt) == SW);
    stat.scan_hit    = free_map[scan_idx] && (rank == '0);
    stat.picks_done  = (picks_left == '0);
  end
endmodule

// File: rtl/core/frma_ctrl.sv
// Controller state machine sequencing requests, allocation and result delivery.
module frma_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_last,
  input  frma_pkg::frma_stat_t stat,
  output frma_pkg::frma_cmd_t  cmd
);
  localparam logic [3:0] S_IDLE = 4'd0, S_DECODE = 4'd1, S_HEAD_RD = 4'd2,
    S_HEAD = 4'd3, S_COUNT = 4'd4, S_MOD = 4'd5, S_SCAN = 4'd6, S_OUT = 4'd7,
    S_REJ = 4'd8, S_FLUSH = 4'd9;

  logic [3:0] state, state_next;
  // A grant loaded in the datapath but not presented yet: whether it is the
  // last of the request is only known at the next pick or at the end.
  logic pend;
  logic ov, ol;
  logic rel_grant, rel_last;

  logic taken;
  assign taken = out_valid && !out_stall;
  assign out_valid = ov;
  assign out_last = ol;
  assign in_stall = (state != S_IDLE) || ov;

  always_comb begin
    cmd = '0;
    state_next = state;
    rel_grant = 1'b0;
    rel_last = 1'b0;
    case (state)
      S_IDLE: if (in_valid && !in_stall) begin
        cmd.take_req = 1'b1; state_next = S_DECODE;
      end
      S_DECODE: begin
        if (stat.req_is_free) begin
          state_next = stat.req_eos ? S_HEAD_RD : S_IDLE;
        end else if (stat.need_zero || stat.queue_full) begin
          cmd.load_reject = 1'b1; state_next = S_REJ;
        end else begin
          cmd.enqueue = 1'b1; state_next = S_HEAD_RD;
        end
      end
      S_HEAD_RD: state_next = stat.queue_empty ? S_FLUSH : S_HEAD;
      S_HEAD: begin cmd.load_head = 1'b1; state_next = S_COUNT; end
      S_COUNT: if (!stat.count_busy) begin
        // A head job that does not fit blocks the queue until the next trigger.
        if (stat.head_fits) begin
          cmd.start_mod = 1'b1; state_next = S_MOD;
        end else state_next = S_FLUSH;
      end
      S_MOD: if (stat.mod_done) begin
        cmd.scan_start = 1'b1; state_next = S_SCAN;
      end else cmd.mod_step = 1'b1;
      S_SCAN: begin
        if (!stat.scan_hit) begin
          cmd.scan_step = 1'b1;
        end else if (pend) begin
          rel_grant = 1'b1;
        end else if (!ov || taken) begin
          cmd.commit_pick = 1'b1; state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.picks_done) begin
          cmd.pop = 1'b1; state_next = S_HEAD_RD;
        end else begin
          cmd.start_mod = 1'b1; state_next = S_MOD;
        end
      end
      S_REJ: if (!ov || taken) state_next = S_IDLE;
      S_FLUSH: begin
        if (pend) begin
          rel_grant = 1'b1; rel_last = 1'b1;
        end else if (!ov || taken) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; ov <= 1'b0; ol <= 1'b0; pend <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_reject) begin
        ov <= 1'b1; ol <= 1'b1;
      end else if (rel_grant) begin
        ov <= 1'b1; ol <= rel_last;
      end else if (taken) begin
        ov <= 1'b0;
      end
      if (rel_grant) pend <= 1'b0;
      else if (cmd.commit_pick) pend <= 1'b1;
    end
  end
endmodule

// File: rtl/core/frma_checker.sv
// Port-level checker for the allocator, bound to the top level.
module frma_props (
  input logic clk, rst, in_valid, in_stall, out_valid, out_stall, last_of_run,
  input logic [1:0] status, input logic [4:0] granted_machine
);
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == frma_pkg::ST_GRANTED || status == frma_pkg::ST_REJ_FULL ||
                   status == frma_pkg::ST_REJ_ZERO)) else $error("status");
  a_rej_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != frma_pkg::ST_GRANTED |-> last_of_run) else $error("reject not last");
  a_rej_mach: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != frma_pkg::ST_GRANTED |-> granted_machine == 5'd0)
    else $error("reject machine");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status)) else $error("hold");
endmodule

bind fifo_random_machine_allocator frma_props u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .last_of_run,
  .status, .granted_machine
);

// File: tb/frma_checker.sv
// Checker for the FIFO random machine allocator: predicts grants and compares them.
`timescale 1ns / 1ps
module frma_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        req_type,
  input  logic [15:0] job_id,
  input  logic [5:0]  need_count,
  input  logic [4:0]  machine_index,
  input  logic        end_of_set,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] grant_job,
  input  logic [4:0]  granted_machine,
  input  logic [1:0]  status,
  input  logic        last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          grants_pending
);

  typedef struct packed {
    logic [15:0] job;
    logic [4:0]  mach;
    logic [1:0]  st;
    logic        last;
  } grant_t;

  grant_t      grant_q[$];
  logic [31:0] free_map;
  logic [5:0]  present;
  logic [15:0] pick_lfsr;
  logic [15:0] jq_id [16];
  logic [5:0]  jq_need [16];
  logic [3:0]  jq_head, jq_tail;
  int          jq_count;

  assign grants_pending = grant_q.size();

  function automatic void add_expected(grant_t g);
    grant_q.insert(grant_q.size(), g);
  endfunction

  function automatic logic [4:0] nth_free(int rank);
    for (int i = 0; i < 32; i++) begin
      if (free_map[i]) begin
        if (rank == 0) return i[4:0];
        rank--;
      end
    end
    return 5'd0;
  endfunction

  // Serve head jobs in order while they fit the free machines and the
  // per-request result budget.
  function automatic void serve_queue();
    int nres;
    int nfree;
    int rank;
    logic [4:0] m;
    grant_t g;
    nres = 0;
    while (jq_count > 0) begin
      nfree = $countones(free_map);
      if (jq_need[jq_head] > nfree) break;
      if (nres + jq_need[jq_head] > frma_pkg::MAX_RESULTS) break;
      for (int j = 0; j < jq_need[jq_head]; j++) begin
        pick_lfsr = (pick_lfsr >> 1) ^ (pick_lfsr[0] ? frma_pkg::LFSR_TAPS : 16'h0);
        rank = pick_lfsr % nfree;
        m = nth_free(rank);
        free_map[m] = 1'b0;
        nfree--;
        g = '{job: jq_id[jq_head], mach: m, st: frma_pkg::ST_GRANTED, last: 1'b0};
        add_expected(g);
        nres++;
      end
      jq_head++;
      jq_count--;
    end
    if (nres > 0) grant_q[grant_q.size()-1].last = 1'b1;
  endfunction

  function automatic void predict_request();
    grant_t g;
    if (req_type == frma_pkg::REQ_ADD) begin
      if (need_count == 0 || jq_count >= 16) begin
        g = '{job: job_id, mach: 5'd0,
              st: (need_count == 0) ? frma_pkg::ST_REJ_ZERO : frma_pkg::ST_REJ_FULL,
              last: 1'b1};
        add_expected(g);
      end else begin
        jq_id[jq_tail] = job_id;
        jq_need[jq_tail] = need_count;
        jq_tail++;
        jq_count++;
        serve_queue();
      end
    end else begin
      if (machine_index < present) free_map[machine_index] = 1'b1;
      if (end_of_set) serve_queue();
    end
  endfunction

  always @(posedge clk) begin
    grant_t e;
    if (rst) begin
      grant_q.delete();
      free_map = 32'hFFFF_FFFF;
      present = 6'd32;
      pick_lfsr = 16'd1;
      jq_head = '0;
      jq_tail = '0;
      jq_count = 0;
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == 1'(frma_pkg::REG_PRESENT)) begin
          present = (pwdata[5:0] > 6'd32) ? 6'd32 : pwdata[5:0];
          free_map = (present == 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << present) - 1);
        end else begin
          pick_lfsr = (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
        end
      end
      if (in_valid && !in_stall) predict_request();
      if (out_valid && !out_stall) begin
        if (grant_q.size() == 0) begin
          $error("unexpected grant: job %0d machine %0d status %0d",
                 grant_job, granted_machine, status);
          fail_count = fail_count + 1;
        end else begin
          e = grant_q.pop_front();
          if (grant_job !== e.job) begin
            $error("grant_job expected %0d actual %0d", e.job, grant_job);
            fail_count = fail_count + 1;
          end
          if (granted_machine !== e.mach) begin
            $error("granted_machine expected %0d actual %0d", e.mach, granted_machine);
            fail_count = fail_count + 1;
          end
          if (status !== e.st) begin
            $error("status expected %0d actual %0d", e.st, status);
            fail_count = fail_count + 1;
          end
          if (last_of_run !== e.last) begin
            $error("last_of_run expected %0d actual %0d", e.last, last_of_run);
            fail_count = fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/fifo_random_machine_allocator_tb.sv
// Testbench top for the FIFO random machine allocator: stimulus and verdict.
`timescale 1ns / 1ps
module fifo_random_machine_allocator_tb;

  // Cycles with no handshake at all before the run is declared hung. The
  // slowest legitimate stretch is a long receiver hold or a settle pause.
  localparam int HANG_LIMIT = 20000;
  // Settle time after the last expected grant, covering a request that
  // produces no result but still walks the free map.
  localparam int SETTLE_CYCLES = 300;
  localparam int LONG_HOLD = 400;

  logic        clk;
  logic        rst;
  logic        in_valid, in_stall;
  logic        req_type;
  logic [15:0] job_id;
  logic [5:0]  need_count;
  logic [4:0]  machine_index;
  logic        end_of_set;
  logic        out_valid, out_stall;
  logic [15:0] grant_job;
  logic [4:0]  granted_machine;
  logic [1:0]  status;
  logic        last_of_run;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  int   fail_count, grants_pending;
  logic in_taken;     // request accepted at the last rising edge
  logic quiet;        // no idling on either side in the closing part
  logic hold_req;     // asks the receiver for one long hold
  int   idle_cycles;

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  fifo_random_machine_allocator dut (.*);

  frma_checker chk (.*);

  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // Watchdog: a run that stops moving is a failure.
  always @(negedge clk) begin
    if (idle_cycles >= HANG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver side: random stall bursts, plus one long hold on request so the
  // allocator backs up and stalls its input.
  initial begin
    int n;
    logic held;
    out_stall = 1'b0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        out_stall = 1'b1;
        for (n = 0; n < LONG_HOLD; n++) @(negedge clk);
        held = 1'b1;
        out_stall = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall = 1'b1;
        n = $urandom_range(1, 12);
        repeat (n) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Registers are written over the APB-style port: setup, then access.
  task automatic reg_write(int index, logic [31:0] value);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = 3'(index * 4); pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // Offer one request and hold it until the allocator takes it. A random
  // gap may come first, so idling lands on every phase of its work.
  task automatic send_request(logic rt, logic [15:0] id, logic [5:0] need,
                              logic [4:0] idx, logic eos);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    req_type = rt; job_id = id; need_count = need;
    machine_index = idx; end_of_set = eos;
    do @(negedge clk); while (!in_taken);
    in_valid = 1'b0;
  endtask

  // Wait until every predicted grant has arrived, then let the block finish
  // any request that produces no result, so it is idle for a register write.
  task automatic drain_and_settle();
    in_valid = 1'b0;
    while (grants_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // A random request: mostly small jobs and frees of real machines, with
  // some zero needs, big gangs and frees of absent machines mixed in.
  task automatic random_request(int present_now);
    int sel;
    logic [5:0] need;
    logic [4:0] idx;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      if (sel < 3) need = 6'd0;
      else if (sel < 8) need = 6'($urandom_range(5, 32));
      else need = 6'($urandom_range(1, 4));
      send_request(frma_pkg::REQ_ADD, 16'($urandom), need, 5'($urandom), 1'($urandom));
    end else begin
      if (present_now > 0 && $urandom_range(0, 9) != 0)
        idx = 5'($urandom_range(0, present_now - 1));
      else
        idx = 5'($urandom);
      send_request(frma_pkg::REQ_FREE, 16'($urandom), 6'($urandom), idx,
                   $urandom_range(0, 9) < 4);
    end
  endtask

  initial begin
    logic [15:0] seeds [5];
    int          presents [5];
    int          eff;
    rst = 1'b1;
    in_valid = 1'b0; req_type = frma_pkg::REQ_ADD; job_id = '0; need_count = '0;
    machine_index = '0; end_of_set = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    quiet = 1'b0; hold_req = 1'b0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Directed part, from the reset configuration: every machine free.
    send_request(frma_pkg::REQ_ADD, 16'h1234, 6'd0, 5'd0, 1'b0);   // zero need rejected
    send_request(frma_pkg::REQ_ADD, 16'hFFFF, 6'd1, 5'd31, 1'b1);  // single grant
    send_request(frma_pkg::REQ_ADD, 16'h0000, 6'd32, 5'd0, 1'b0);  // blocks, 31 free
    send_request(frma_pkg::REQ_FREE, 16'h0, 6'd0, 5'd31, 1'b0);    // free without trigger
    send_request(frma_pkg::REQ_FREE, 16'h0, 6'd0, 5'd31, 1'b0);    // free of a free machine
    send_request(frma_pkg::REQ_FREE, 16'h0, 6'd0, 5'd0, 1'b1);     // trigger: gang of 32
    // Fill the queue with nothing free, so the overflow is rejected.
    for (int k = 0; k < 17; k++)
      send_request(frma_pkg::REQ_ADD, 16'(16'hA000 + k), 6'(k % 2 ? 32 : 1), 5'd0, 1'b0);
    drain_and_settle();
    // A reload of the present machines and a trigger release the first queued job.
    reg_write(frma_pkg::REG_PRESENT, 32'd32);
    send_request(frma_pkg::REQ_FREE, 16'h0, 6'd0, 5'd7, 1'b1);
    drain_and_settle();

    // Random phases under several settings, the extremes among them. The
    // queue is kept across writes, so each phase starts where the last ended.
    seeds    = '{16'($urandom_range(1, 65535)), 16'hFFFF, 16'h0000,
                 16'($urandom_range(1, 65535)), 16'h0001};
    presents = '{32, 5, 0, 63, 17};
    for (int p = 0; p < 5; p++) begin
      reg_write(frma_pkg::REG_SEED, 32'(seeds[p]));
      reg_write(frma_pkg::REG_PRESENT, 32'(presents[p]));
      eff = (presents[p] > 32) ? 32 : presents[p];
      if (p == 4) quiet = 1'b1;
      for (int k = 0; k < 60; k++) begin
        if (p == 0 && k == 10) hold_req = 1'b1;
        random_request(eff);
      end
      // Sender pauses here until every grant is in.
      drain_and_settle();
    end

    if (fail_count == 0 && grants_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
